### rtl/fac_pkg.sv
package fac_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  // One request as it travels from the front to the back. A test carries
  // both candidate corners per axis (minimum corner and maximum corner);
  // the back picks one by the sign of each normal component.
  typedef struct packed {
    op_t              kind;
    logic [2:0]       index;
    logic [2:0][15:0] normal;
    logic [31:0]      offset;
    logic [2:0][31:0] corner_lo;
    logic [2:0][31:0] corner_hi;
  } cmd_t;

  localparam int CMD_W      = $bits(cmd_t);
  localparam int PROD_W     = 48;
  localparam int ACC_W      = 52;
  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

endpackage

### rtl/frustum_aabb_cull_core.sv
// Throughput: one request per cycle, loads and tests alike, unless the pipeline holds on
// a full result queue; each plane has its own lane of three multipliers and one
// accumulate-and-compare, all planes in parallel. Loads return no result. Reset (rst,
// synchronous) empties both queues, clears the pipeline and sets every stored plane to
// zero, so every box tests visible until loaded.
module frustum_aabb_cull_core import fac_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [2:0]         plane_index,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [31:0] plane_offset,
  input  logic signed [30:0] box_origin_x,
  input  logic signed [30:0] box_origin_y,
  input  logic signed [30:0] box_origin_z,
  input  logic [29:0]        box_size_x,
  input  logic [29:0]        box_size_y,
  input  logic [29:0]        box_size_z,
  output logic               empty,
  input  logic               pop,
  output logic               visible
);

  logic             q_push;
  cmd_t             q_cmd;
  logic [CMD_W-1:0] q_rdata;
  cmd_t             b_cmd;
  logic             q_empty;
  logic             q_pop;
  logic             res_full;
  logic             res_push;
  logic             res_visible;

  fac_front #(
    .NUM_PLANES(NUM_PLANES)
  ) u_front (
    .push(push),
    .operation(operation),
    .plane_index(plane_index),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .normal_z(normal_z),
    .plane_offset(plane_offset),
    .box_origin_x(box_origin_x),
    .box_origin_y(box_origin_y),
    .box_origin_z(box_origin_z),
    .box_size_x(box_size_x),
    .box_size_y(box_size_y),
    .box_size_z(box_size_z),
    .q_full(full),
    .q_push(q_push),
    .q_cmd(q_cmd)
  );

  fac_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata(q_cmd),
    .full(full),
    .pop(q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign b_cmd = cmd_t'(q_rdata);

  fac_back #(
    .NUM_PLANES(NUM_PLANES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_empty(q_empty),
    .cmd(b_cmd),
    .cmd_pop(q_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res_visible(res_visible)
  );

  fac_fifo #(
    .WIDTH(1),
    .DEPTH(RESQ_DEPTH)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata(res_visible),
    .full(res_full),
    .pop(pop),
    .rdata(visible),
    .empty(empty)
  );

endmodule

### rtl/fac_fifo.sv
module fac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/fac_front.sv
module fac_front import fac_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic               push,
  input  logic               operation,
  input  logic [2:0]         plane_index,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [31:0] plane_offset,
  input  logic signed [30:0] box_origin_x,
  input  logic signed [30:0] box_origin_y,
  input  logic signed [30:0] box_origin_z,
  input  logic [29:0]        box_size_x,
  input  logic [29:0]        box_size_y,
  input  logic [29:0]        box_size_z,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  localparam logic [3:0] PLANE_LIMIT = 4'(NUM_PLANES);

  logic is_test;
  logic index_ok;
  logic [2:0][30:0] origin;
  logic [2:0][29:0] size;

  assign is_test  = (operation == OP_TEST);
  assign index_ok = ({1'b0, plane_index} < PLANE_LIMIT);

  assign origin = {box_origin_z, box_origin_y, box_origin_x};
  assign size   = {box_size_z, box_size_y, box_size_x};

  // A load to a slot that does not exist has no effect, so it is dropped here.
  assign q_push = push && !q_full && (is_test || index_ok);

  always_comb begin
    q_cmd.kind   = is_test ? OP_TEST : OP_LOAD;
    q_cmd.index  = plane_index;
    q_cmd.normal = {normal_z, normal_y, normal_x};
    q_cmd.offset = plane_offset;
    for (int k = 0; k < 3; k++) begin
      q_cmd.corner_lo[k] = {origin[k][30], origin[k]};
      q_cmd.corner_hi[k] = {origin[k][30], origin[k]} + {2'b00, size[k]};
    end
  end

endmodule

### rtl/fac_back.sv
module fac_back import fac_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output logic res_visible
);

  localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  logic signed [15:0] plane_n [NUM_PLANES][3];
  logic signed [31:0] plane_d [NUM_PLANES];

  logic en;
  logic issue;
  logic [PIDX_W-1:0] widx;

  logic             s1_valid;
  logic [2:0][31:0] s1_lo;
  logic [2:0][31:0] s1_hi;

  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_prod [NUM_PLANES][3];
  logic signed [31:0]       s2_d    [NUM_PLANES];
  logic signed [PROD_W-1:0] prod_next [NUM_PLANES][3];

  logic s3_valid;
  logic s3_visible;
  logic visible_next;

  // The whole pipeline holds while a finished result cannot enter the queue.
  assign en       = !(s3_valid && res_full);
  assign issue    = !cmd_empty && en;
  assign cmd_pop  = issue;
  assign widx     = cmd.index[PIDX_W-1:0];
  assign res_push = s3_valid && en;
  assign res_visible = s3_visible;

  // Per plane only one corner matters: the one farthest along the normal.
  // n*(2*o + s) + |n|*s equals 2*n*(o + s) for n >= 0 and 2*n*o otherwise.
  always_comb begin
    logic signed [31:0] v;
    v = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 3; k++) begin
        v = plane_n[p][k][15] ? $signed(s1_lo[k]) : $signed(s1_hi[k]);
        prod_next[p][k] = plane_n[p][k] * v;
      end
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    acc = '0;
    visible_next = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = ACC_W'(s2_prod[p][0]) + ACC_W'(s2_prod[p][1]) + ACC_W'(s2_prod[p][2]);
      acc = (acc <<< 1) - (ACC_W'(s2_d[p]) <<< 15);
      if (acc[ACC_W-1]) begin
        visible_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < 3; k++) begin
          plane_n[p][k] <= '0;
        end
        plane_d[p] <= '0;
      end
    end else if (en) begin
      s1_valid <= issue && (cmd.kind == OP_TEST);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (issue && (cmd.kind == OP_LOAD)) begin
        for (int k = 0; k < 3; k++) begin
          plane_n[widx][k] <= $signed(cmd.normal[k]);
        end
        plane_d[widx] <= $signed(cmd.offset);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lo <= cmd.corner_lo;
      s1_hi <= cmd.corner_hi;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < 3; k++) begin
          s2_prod[p][k] <= prod_next[p][k];
        end
        s2_d[p] <= plane_d[p];
      end
      s3_visible <= visible_next;
    end
  end

endmodule

### dv/frustum_cull_checker.sv
module frustum_cull_checker import fac_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic               operation,
  input  logic [2:0]         plane_index,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [31:0] plane_offset,
  input  logic signed [30:0] box_origin_x,
  input  logic signed [30:0] box_origin_y,
  input  logic signed [30:0] box_origin_z,
  input  logic [29:0]        box_size_x,
  input  logic [29:0]        box_size_y,
  input  logic [29:0]        box_size_z,
  input  logic               empty,
  input  logic               pop,
  input  logic               visible,
  output int                 fault_count,
  output int                 results_owed
);

  logic signed [15:0] normal_tab [NUM_PLANES][3];
  logic signed [31:0] offset_tab [NUM_PLANES];
  bit                 visibility_due [$];

  // Everything is kept at a common scale of 2^15: twice the center times a
  // Q1.14 normal, the full size times its magnitude, and the offset times 2^15.
  function automatic bit box_survives_planes(
      input logic signed [30:0] ox, oy, oz,
      input logic [29:0]        sx, sy, sz);
    longint twice_center [3];
    longint span [3];
    longint acc;
    longint n;
    bit     keep;
    span[0] = longint'(sx);
    span[1] = longint'(sy);
    span[2] = longint'(sz);
    twice_center[0] = 2 * longint'(ox) + span[0];
    twice_center[1] = 2 * longint'(oy) + span[1];
    twice_center[2] = 2 * longint'(oz) + span[2];
    keep = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = -(longint'(offset_tab[p]) * 64'sd32768);
      for (int k = 0; k < 3; k++) begin
        n = longint'(normal_tab[p][k]);
        acc += n * twice_center[k] + ((n < 0) ? -n : n) * span[k];
      end
      if (acc < 0) keep = 1'b0;
    end
    return keep;
  endfunction

  task automatic note_fault(input string what, input int want, input int got);
    fault_count++;
    if (fault_count <= 10)
      $display("[%0t] %s: expected visible=%0d, got visible=%0d", $realtime, what, want, got);
  endtask

  initial begin
    fault_count  = 0;
    results_owed = 0;
  end

  always @(posedge clk) begin : watch
    bit want;
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < 3; k++) normal_tab[p][k] = '0;
        offset_tab[p] = '0;
      end
      visibility_due.delete();
    end else begin
      if (pop && !empty) begin
        if (visibility_due.size() == 0) begin
          note_fault("result with no request pending", -1, int'(visible));
        end else begin
          want = visibility_due.pop_front();
          if (visible !== want) note_fault("visibility mismatch", int'(want), int'(visible));
        end
      end
      if (push && !full) begin
        if (operation == OP_LOAD) begin
          // Loads aimed past the last plane slot are dropped.
          if (plane_index < NUM_PLANES) begin
            normal_tab[plane_index][0] = normal_x;
            normal_tab[plane_index][1] = normal_y;
            normal_tab[plane_index][2] = normal_z;
            offset_tab[plane_index]    = plane_offset;
          end
        end else begin
          visibility_due.push_back(box_survives_planes(box_origin_x, box_origin_y,
              box_origin_z, box_size_x, box_size_y, box_size_z));
        end
      end
    end
    results_owed <= visibility_due.size();
  end

endmodule

### dv/tb_frustum_aabb_cull_core.sv
module tb_frustum_aabb_cull_core import fac_pkg::*;;

  localparam logic signed [30:0] ORG_MIN  = 31'sh40000000;
  localparam logic signed [30:0] ORG_MAX  = 31'sh3fffffff;
  localparam logic [29:0]        SIZE_MAX = 30'h3fffffff;
  localparam int                 UNIT     = 16384;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic               operation;
  logic [2:0]         plane_index;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] plane_offset;
  logic signed [30:0] box_origin_x;
  logic signed [30:0] box_origin_y;
  logic signed [30:0] box_origin_z;
  logic [29:0]        box_size_x;
  logic [29:0]        box_size_y;
  logic [29:0]        box_size_z;
  logic               empty;
  logic               pop;
  logic               visible;
  int                 fault_count;
  int                 results_owed;

  int idle_pct;
  int stall_pct;
  bit hold_armed;

  frustum_aabb_cull_core #(.NUM_PLANES(6)) i_dut (.*);
  frustum_cull_checker #(.NUM_PLANES(6)) i_checker (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #4000000;
    $display("frustum_aabb_cull_core verification failed");
    $finish;
  end

  // Result side. A single long hold-off is counted here once it is armed.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    pop       = 1'b0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic pace_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic await_accept();
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Box fields are ignored by a load, so they carry random noise.
  task automatic load_plane(input logic [2:0] idx, input logic signed [15:0] nx, ny, nz,
                            input logic signed [31:0] d);
    pace_gap();
    push         <= 1'b1;
    operation    <= OP_LOAD;
    plane_index  <= idx;
    normal_x     <= nx;
    normal_y     <= ny;
    normal_z     <= nz;
    plane_offset <= d;
    box_origin_x <= 31'($urandom());
    box_origin_y <= 31'($urandom());
    box_origin_z <= 31'($urandom());
    box_size_x   <= 30'($urandom());
    box_size_y   <= 30'($urandom());
    box_size_z   <= 30'($urandom());
    await_accept();
  endtask

  task automatic test_box(input logic signed [30:0] ox, oy, oz,
                          input logic [29:0] sx, sy, sz);
    pace_gap();
    push         <= 1'b1;
    operation    <= OP_TEST;
    plane_index  <= 3'($urandom());
    normal_x     <= 16'($urandom());
    normal_y     <= 16'($urandom());
    normal_z     <= 16'($urandom());
    plane_offset <= $urandom();
    box_origin_x <= ox;
    box_origin_y <= oy;
    box_origin_z <= oz;
    box_size_x   <= sx;
    box_size_y   <= sy;
    box_size_z   <= sz;
    await_accept();
  endtask

  function automatic int near_zero(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_load();
    logic [2:0] idx;
    int         axis;
    int         n [3];
    idx = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: load_plane(idx, 16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom());
      1: load_plane(idx, 16'(near_zero(UNIT)), 16'(near_zero(UNIT)), 16'(near_zero(UNIT)),
                    near_zero(1 << 20));
      2: load_plane(idx, 0, 0, 0, 0);
      default: begin
        // Axis-aligned plane, the usual shape of a near, far or side plane.
        axis = $urandom_range(0, 2);
        n = '{0, 0, 0};
        n[axis] = $urandom_range(0, 1) ? UNIT : -UNIT;
        load_plane(idx, 16'(n[0]), 16'(n[1]), 16'(n[2]), near_zero(1 << 20));
      end
    endcase
  endtask

  task automatic random_test();
    if ($urandom_range(0, 3) == 0)
      test_box(31'($urandom()), 31'($urandom()), 31'($urandom()),
               30'($urandom()), 30'($urandom()), 30'($urandom()));
    else
      test_box(31'(near_zero(1 << 20)), 31'(near_zero(1 << 20)), 31'(near_zero(1 << 20)),
               30'($urandom_range(0, 1 << 21)), 30'($urandom_range(0, 1 << 21)),
               30'($urandom_range(0, 1 << 21)));
  endtask

  task automatic random_request();
    if ($urandom_range(0, 99) < 30) random_load();
    else random_test();
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 80, 0, 19};
    stall_tab = '{0, 0, 80, 19};
    rst          = 1'b1;
    push         = 1'b0;
    operation    = OP_LOAD;
    plane_index  = '0;
    normal_x     = '0;
    normal_y     = '0;
    normal_z     = '0;
    plane_offset = '0;
    box_origin_x = '0;
    box_origin_y = '0;
    box_origin_z = '0;
    box_size_x   = '0;
    box_size_y   = '0;
    box_size_z   = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_armed   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // With every plane zero, any box is visible.
    test_box(ORG_MIN, ORG_MIN, ORG_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX);
    test_box(ORG_MAX, ORG_MAX, ORG_MAX, 0, 0, 0);
    load_plane(0, 16'(UNIT), 0, 0, 0);
    // A point exactly on the plane passes; one just behind it does not.
    test_box(0, 0, 0, 0, 0, 0);
    test_box(-1, 5, 5, 0, 0, 0);
    test_box(-2, 0, 0, 2, 0, 0);
    // Plane slots six and seven do not exist, so these loads change nothing.
    load_plane(6, -32768, -32768, -32768, 32'sh7fffffff);
    load_plane(7, 32767, 32767, 32767, 32'sh7fffffff);
    test_box(0, 0, 0, 0, 0, 0);
    load_plane(1, -32768, -32768, -32768, 32'sh80000000);
    load_plane(2, 32767, 32767, 32767, 32'sh7fffffff);
    test_box(ORG_MAX, ORG_MAX, ORG_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX);
    test_box(ORG_MIN, ORG_MIN, ORG_MIN, 0, 0, 0);
    load_plane(3, 0, -16'(UNIT), 0, -65536);
    load_plane(5, 0, 0, 16'(UNIT), 0);
    test_box(0, 0, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX);
    for (int p = 0; p < 6; p++) load_plane(3'(p), 0, 0, 0, 0);
    test_box(ORG_MIN, ORG_MAX, 0, SIZE_MAX, 0, SIZE_MAX);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      repeat (225) random_request();
    end

    // Hold the result side off while tests keep coming, so the block backs
    // up and raises full; then stop sending until everything has drained.
    idle_pct   = 0;
    stall_pct  = 0;
    hold_armed = 1;
    repeat (40) random_test();
    drain();

    stall_pct = 19;
    idle_pct  = 19;
    repeat (30) random_request();
    drain();
    repeat (10) @(posedge clk);

    if (fault_count == 0)
      $display("frustum_aabb_cull_core verification clean");
    else
      $display("frustum_aabb_cull_core verification failed");
    $finish;
  end

endmodule

### files.f
rtl/fac_pkg.sv
rtl/fac_fifo.sv
rtl/fac_front.sv
rtl/fac_back.sv
rtl/frustum_aabb_cull_core.sv
dv/frustum_cull_checker.sv
dv/tb_frustum_aabb_cull_core.sv
